### hdl/fbsc_pkg.sv
`timescale 1ns / 1ps

package fbsc_pkg;

  // Error mask bit positions.
  localparam int unsigned ErrSector   = 0;
  localparam int unsigned ErrCluster  = 1;
  localparam int unsigned ErrTotal    = 2;
  localparam int unsigned ErrReserved = 3;
  localparam int unsigned ErrFatSect  = 4;
  localparam int unsigned ErrFatCount = 5;
  localparam int unsigned ErrBits     = 6;

  // Cluster count thresholds between the FAT variants.
  localparam logic [31:0] LimitFat12 = 32'd4085;
  localparam logic [31:0] LimitFat16 = 32'd65525;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_FAT12 = 2'd1,
    KIND_FAT16 = 2'd2,
    KIND_FAT32 = 2'd3
  } fat_kind_e;

  // Item state handed from the check stages to the layout stages.
  typedef struct packed {
    logic               valid;
    logic [ErrBits-1:0] err;
    logic [32:0]        meta;    // reserved + FAT area + root directory sectors
    logic [32:0]        pre;     // reserved + FAT area sectors
    logic [38:0]        rel_sh;  // (root cluster - 2) scaled to sectors
    logic [31:0]        total;
    logic [15:0]        resv;
    logic [1:0]         sshift;  // sector size is 512 << sshift
    logic [2:0]         cshift;  // sectors per cluster is 1 << cshift
  } fbsc_mid_t;

endpackage

### hdl/fbsc_check.sv
`timescale 1ns / 1ps

module fbsc_check (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [15:0]       sector_bytes_i,
  input  logic [7:0]        cluster_sectors_i,
  input  logic [15:0]       total_sectors_short_i,
  input  logic [31:0]       total_sectors_long_i,
  input  logic [15:0]       reserved_sectors_i,
  input  logic [15:0]       fat_sectors_short_i,
  input  logic [31:0]       fat_sectors_long_i,
  input  logic [7:0]        fat_copies_i,
  input  logic [15:0]       root_entries_i,
  input  logic [31:0]       root_cluster_i,
  output fbsc_pkg::fbsc_mid_t mid_o
);
  import fbsc_pkg::*;

  // Stage 1: field selection and the simple checks.
  logic        s1_valid_q;
  logic        s1_err_sec_q, s1_err_clu_q, s1_tot_zero_q, s1_err_res_q, s1_err_fs_q;
  logic        s1_nfat_zero_q;
  logic [1:0]  s1_sshift_q;
  logic [2:0]  s1_cshift_q;
  logic [31:0] s1_total_q, s1_spf_q, s1_rclus_q;
  logic [15:0] s1_resv_q, s1_nroot_q;
  logic [7:0]  s1_nfat_q;

  logic [31:0] total_d, spf_d;
  logic        tot_zero_d;
  logic [2:0]  cshift_d;

  always_comb begin
    total_d    = (total_sectors_short_i != 16'd0) ? {16'd0, total_sectors_short_i}
                                                  : total_sectors_long_i;
    spf_d      = (fat_sectors_short_i != 16'd0) ? {16'd0, fat_sectors_short_i}
                                                : fat_sectors_long_i;
    tot_zero_d = (total_d == 32'd0);
    cshift_d   = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (cluster_sectors_i[i]) begin
        cshift_d = 3'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_err_sec_q   <= !(sector_bytes_i inside {16'd512, 16'd1024, 16'd2048, 16'd4096});
    s1_err_clu_q   <= (cluster_sectors_i == 8'd0) ||
                      ((cluster_sectors_i & (cluster_sectors_i - 8'd1)) != 8'd0);
    s1_tot_zero_q  <= tot_zero_d;
    s1_err_res_q   <= !tot_zero_d && ({16'd0, reserved_sectors_i} > total_d);
    s1_err_fs_q    <= (spf_d == 32'd0) || (!tot_zero_d && (spf_d > total_d));
    s1_nfat_zero_q <= (fat_copies_i == 8'd0);
    s1_sshift_q    <= {sector_bytes_i[12] | sector_bytes_i[11],
                       sector_bytes_i[12] | sector_bytes_i[10]};
    s1_cshift_q    <= cshift_d;
    s1_total_q     <= total_d;
    s1_spf_q       <= spf_d;
    s1_rclus_q     <= root_cluster_i;
    s1_resv_q      <= reserved_sectors_i;
    s1_nroot_q     <= root_entries_i;
    s1_nfat_q      <= fat_copies_i;
  end

  // Stage 2: FAT area product and root directory size in sectors.
  logic        s2_valid_q;
  logic [4:0]  s2_err_q;
  logic        s2_nfat_zero_q;
  logic [39:0] s2_fatarea_q;
  logic [12:0] s2_rootsect_q;
  logic [1:0]  s2_sshift_q;
  logic [2:0]  s2_cshift_q;
  logic [31:0] s2_total_q, s2_rclus_q;
  logic [15:0] s2_resv_q;

  logic [16:0] rs_sum_d;
  logic [16:0] rs_div_d;

  always_comb begin
    // Entries are 32 bytes, so a sector holds 16 << sshift of them.
    rs_sum_d = {1'b0, s1_nroot_q} + ((17'd16 << s1_sshift_q) - 17'd1);
    rs_div_d = rs_sum_d >> (3'd4 + {1'b0, s1_sshift_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_err_q       <= {s1_err_fs_q, s1_err_res_q, s1_tot_zero_q, s1_err_clu_q, s1_err_sec_q};
    s2_nfat_zero_q <= s1_nfat_zero_q;
    s2_fatarea_q   <= {32'd0, s1_nfat_q} * {8'd0, s1_spf_q};
    s2_rootsect_q  <= rs_div_d[12:0];
    s2_sshift_q    <= s1_sshift_q;
    s2_cshift_q    <= s1_cshift_q;
    s2_total_q     <= s1_total_q;
    s2_rclus_q     <= s1_rclus_q;
    s2_resv_q      <= s1_resv_q;
  end

  // Stage 3: FAT area check and metadata sums.
  fbsc_mid_t s3_q;
  logic      err_cnt_d;

  always_comb begin
    err_cnt_d = s2_nfat_zero_q ||
                (!s2_err_q[ErrTotal] && !s2_err_q[ErrFatSect] &&
                 (s2_fatarea_q > {8'd0, s2_total_q}));
  end

  // Only the valid bit is cleared by reset; the other fields simply hold.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_q.valid <= 1'b0;
    end else begin
      s3_q.valid  <= s2_valid_q;
      s3_q.err    <= {err_cnt_d, s2_err_q};
      s3_q.pre    <= {17'd0, s2_resv_q} + {1'b0, s2_fatarea_q[31:0]};
      s3_q.meta   <= {17'd0, s2_resv_q} + {1'b0, s2_fatarea_q[31:0]} + {20'd0, s2_rootsect_q};
      s3_q.rel_sh <= {7'd0, s2_rclus_q - 32'd2} << s2_cshift_q;
      s3_q.total  <= s2_total_q;
      s3_q.resv   <= s2_resv_q;
      s3_q.sshift <= s2_sshift_q;
      s3_q.cshift <= s2_cshift_q;
    end
  end

  assign mid_o = s3_q;

endmodule

### hdl/fbsc_layout.sv
`timescale 1ns / 1ps

module fbsc_layout (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fbsc_pkg::fbsc_mid_t mid_i,
  output logic                done_o,
  output logic [5:0]          error_mask_o,
  output fbsc_pkg::fat_kind_e fat_kind_o,
  output logic [31:0]         cluster_total_o,
  output logic [27:0]         fat_offset_o,
  output logic [51:0]         root_offset_o,
  output logic [52:0]         data_offset_o,
  output logic [43:0]         data_bytes_o
);
  import fbsc_pkg::*;

  // Multiply a sector count by the sector size, which is 512 << s.
  function automatic logic [52:0] scale(input logic [39:0] v, input logic [1:0] s);
    scale = {13'd0, v} << (4'd9 + {2'd0, s});
  endfunction

  // Stage 4: data sectors, clusters and the FAT32 root sector.
  logic               s4_valid_q;
  logic [ErrBits-1:0] s4_err_q;
  logic [31:0]        s4_datasect_q, s4_clusters_q;
  logic [39:0]        s4_rootsum_q;
  logic [32:0]        s4_pre_q, s4_meta_q;
  logic [15:0]        s4_resv_q;
  logic [1:0]         s4_sshift_q;
  logic [31:0]        datasect_d;

  assign datasect_d = mid_i.total - mid_i.meta[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else begin
      s4_valid_q <= mid_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_err_q      <= mid_i.err;
    s4_datasect_q <= datasect_d;
    s4_clusters_q <= datasect_d >> mid_i.cshift;
    s4_rootsum_q  <= {1'b0, mid_i.rel_sh} + {7'd0, mid_i.meta};
    s4_pre_q      <= mid_i.pre;
    s4_meta_q     <= mid_i.meta;
    s4_resv_q     <= mid_i.resv;
    s4_sshift_q   <= mid_i.sshift;
  end

  // Stage 5: classification, byte offsets and the result register.
  fat_kind_e   kind_d;
  logic        ok_d;
  logic [52:0] fatoff_d, rootoff_d, dataoff_d, databytes_d;

  always_comb begin
    ok_d = (s4_err_q == '0);
    if (s4_clusters_q < LimitFat12) begin
      kind_d = KIND_FAT12;
    end else if (s4_clusters_q < LimitFat16) begin
      kind_d = KIND_FAT16;
    end else begin
      kind_d = KIND_FAT32;
    end
    fatoff_d    = scale({24'd0, s4_resv_q}, s4_sshift_q);
    databytes_d = scale({8'd0, s4_datasect_q}, s4_sshift_q);
    if (kind_d == KIND_FAT32) begin
      rootoff_d = scale(s4_rootsum_q, s4_sshift_q);
      dataoff_d = scale({7'd0, s4_pre_q}, s4_sshift_q);
    end else begin
      rootoff_d = scale({7'd0, s4_pre_q}, s4_sshift_q);
      dataoff_d = scale({7'd0, s4_meta_q}, s4_sshift_q);
    end
  end

  logic done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    error_mask_o    <= s4_err_q;
    fat_kind_o      <= ok_d ? kind_d : KIND_NONE;
    cluster_total_o <= ok_d ? s4_clusters_q : 32'd0;
    fat_offset_o    <= ok_d ? fatoff_d[27:0] : 28'd0;
    root_offset_o   <= ok_d ? rootoff_d[51:0] : 52'd0;
    data_offset_o   <= ok_d ? dataoff_d : 53'd0;
    data_bytes_o    <= ok_d ? databytes_d[43:0] : 44'd0;
  end

  assign done_o = done_q;

endmodule

### hdl/fat_boot_sector_checker.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// command   in         start_i, busy_o      boot sector parameter fields (*_i)
// result    out        done_o (strobe)      error_mask_o, fat_kind_o, sizes, offsets
//
// An item is taken at every rising edge where start_i is high; busy_o is held low
// because the five-stage pipeline advances on every cycle. Each item's result is
// on done_o once the item has left the last stage; new items enter while earlier
// ones are in flight, so the block sustains one item per cycle. The depth is set
// by the FAT area multiply and the chain of sector sums and byte scaling that
// follows it. The receiver cannot stall, so the pipeline never holds. Reset
// clears only the valid bits of the stages.
module fat_boot_sector_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [15:0] sector_bytes_i,
  input  logic [7:0]  cluster_sectors_i,
  input  logic [15:0] total_sectors_short_i,
  input  logic [31:0] total_sectors_long_i,
  input  logic [15:0] reserved_sectors_i,
  input  logic [15:0] fat_sectors_short_i,
  input  logic [31:0] fat_sectors_long_i,
  input  logic [7:0]  fat_copies_i,
  input  logic [15:0] root_entries_i,
  input  logic [31:0] root_cluster_i,
  output logic        done_o,
  output logic [5:0]  error_mask_o,
  output logic [1:0]  fat_kind_o,
  output logic [31:0] cluster_total_o,
  output logic [27:0] fat_offset_o,
  output logic [51:0] root_offset_o,
  output logic [52:0] data_offset_o,
  output logic [43:0] data_bytes_o
);
  import fbsc_pkg::*;

  // Stages one to three check the fields and form the sector sums of the
  // layout; stages four and five derive clusters, classify the volume and
  // scale sector counts to byte offsets.
  fbsc_mid_t mid;
  fat_kind_e kind;

  assign busy_o = 1'b0;

  fbsc_check u_check (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .valid_i               (start_i),
    .sector_bytes_i        (sector_bytes_i),
    .cluster_sectors_i     (cluster_sectors_i),
    .total_sectors_short_i (total_sectors_short_i),
    .total_sectors_long_i  (total_sectors_long_i),
    .reserved_sectors_i    (reserved_sectors_i),
    .fat_sectors_short_i   (fat_sectors_short_i),
    .fat_sectors_long_i    (fat_sectors_long_i),
    .fat_copies_i          (fat_copies_i),
    .root_entries_i        (root_entries_i),
    .root_cluster_i        (root_cluster_i),
    .mid_o                 (mid)
  );

  fbsc_layout u_layout (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .mid_i           (mid),
    .done_o          (done_o),
    .error_mask_o    (error_mask_o),
    .fat_kind_o      (kind),
    .cluster_total_o (cluster_total_o),
    .fat_offset_o    (fat_offset_o),
    .root_offset_o   (root_offset_o),
    .data_offset_o   (data_offset_o),
    .data_bytes_o    (data_bytes_o)
  );

  assign fat_kind_o = kind;

endmodule

### sim/fbsc_layout_checker.sv
`timescale 1ns / 1ps

module fbsc_layout_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [15:0] sector_bytes_i,
  input  logic [7:0]  cluster_sectors_i,
  input  logic [15:0] total_sectors_short_i,
  input  logic [31:0] total_sectors_long_i,
  input  logic [15:0] reserved_sectors_i,
  input  logic [15:0] fat_sectors_short_i,
  input  logic [31:0] fat_sectors_long_i,
  input  logic [7:0]  fat_copies_i,
  input  logic [15:0] root_entries_i,
  input  logic [31:0] root_cluster_i,
  input  logic        done_i,
  input  logic [5:0]  error_mask_i,
  input  logic [1:0]  fat_kind_i,
  input  logic [31:0] cluster_total_i,
  input  logic [27:0] fat_offset_i,
  input  logic [51:0] root_offset_i,
  input  logic [52:0] data_offset_i,
  input  logic [43:0] data_bytes_i,
  output int unsigned pending_o,
  output int unsigned mismatches_o
);
  import fbsc_pkg::*;

  typedef struct packed {
    logic [15:0] sector_bytes;
    logic [7:0]  cluster_sectors;
    logic [15:0] total_short;
    logic [31:0] total_long;
    logic [15:0] reserved;
    logic [15:0] fat_short;
    logic [31:0] fat_long;
    logic [7:0]  fat_copies;
    logic [15:0] root_entries;
    logic [31:0] root_cluster;
  } sector_fields_t;

  typedef struct packed {
    logic [ErrBits-1:0] err;
    fat_kind_e          kind;
    logic [31:0]        clusters;
    logic [27:0]        fat_offset;
    logic [51:0]        root_offset;
    logic [52:0]        data_offset;
    logic [43:0]        data_bytes;
  } layout_t;

  layout_t     expected_layouts[$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;

  assign mismatches_o = mismatches;

  // Checks and byte layout of one boot sector, all sums in 64 bits.
  function automatic layout_t layout_of(sector_fields_t f);
    logic [63:0] ssz, csz, total, spf, nfat, resv;
    logic [63:0] root_sects, fat_area, meta, data_sects, fat_bytes, rel, fat_off;
    layout_t     r;
    ssz  = f.sector_bytes;
    csz  = f.cluster_sectors;
    resv = f.reserved;
    nfat = f.fat_copies;
    r    = '0;
    if (!(ssz inside {64'd512, 64'd1024, 64'd2048, 64'd4096})) begin
      r.err[ErrSector] = 1'b1;
    end
    if (csz == 0 || (csz & (csz - 1)) != 0) begin
      r.err[ErrCluster] = 1'b1;
    end
    total = (f.total_short != 0) ? 64'(f.total_short) : 64'(f.total_long);
    if (total == 0) begin
      r.err[ErrTotal] = 1'b1;
    end
    if (!r.err[ErrTotal] && resv > total) begin
      r.err[ErrReserved] = 1'b1;
    end
    spf = (f.fat_short != 0) ? 64'(f.fat_short) : 64'(f.fat_long);
    if (spf == 0 || (!r.err[ErrTotal] && spf > total)) begin
      r.err[ErrFatSect] = 1'b1;
    end
    if (nfat == 0 || (!r.err[ErrTotal] && !r.err[ErrFatSect] && nfat * spf > total)) begin
      r.err[ErrFatCount] = 1'b1;
    end
    if (r.err == '0) begin
      root_sects = (64'(f.root_entries) * 32 + ssz - 1) / ssz;
      fat_area   = nfat * spf;
      meta       = resv + fat_area + root_sects;
      data_sects = (total - meta) & 64'hFFFF_FFFF;
      fat_bytes  = spf * ssz;
      fat_off    = resv * ssz;
      r.clusters   = 32'(data_sects / csz);
      r.fat_offset = fat_off[27:0];
      r.data_bytes = 44'(data_sects * ssz);
      if (64'(r.clusters) < 64'(LimitFat12)) begin
        r.kind = KIND_FAT12;
      end else if (64'(r.clusters) < 64'(LimitFat16)) begin
        r.kind = KIND_FAT16;
      end else begin
        r.kind = KIND_FAT32;
      end
      if (r.kind == KIND_FAT32) begin
        rel           = (64'(f.root_cluster) - 2) & 64'hFFFF_FFFF;
        r.root_offset = 52'((rel * csz + meta) * ssz);
        r.data_offset = 53'(fat_off + fat_bytes * nfat);
      end else begin
        r.root_offset = 52'(fat_off + fat_bytes * nfat);
        r.data_offset = 53'(fat_off + fat_bytes * nfat + root_sects * ssz);
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: result %0d: %s", $time, results_seen, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  always @(posedge clk_i) begin : sample
    sector_fields_t item;
    layout_t        want;
    if (rst_ni) begin
      if (start_i && !busy_i) begin
        item.sector_bytes    = sector_bytes_i;
        item.cluster_sectors = cluster_sectors_i;
        item.total_short     = total_sectors_short_i;
        item.total_long      = total_sectors_long_i;
        item.reserved        = reserved_sectors_i;
        item.fat_short       = fat_sectors_short_i;
        item.fat_long        = fat_sectors_long_i;
        item.fat_copies      = fat_copies_i;
        item.root_entries    = root_entries_i;
        item.root_cluster    = root_cluster_i;
        expected_layouts.insert(expected_layouts.size(), layout_of(item));
      end
      if (done_i) begin
        if (expected_layouts.size() == 0) begin
          report_mismatch("result with no item outstanding");
        end else begin
          want = expected_layouts.pop_front();
          check_field("error_mask", error_mask_i, want.err);
          check_field("fat_kind", fat_kind_i, want.kind);
          check_field("cluster_total", cluster_total_i, want.clusters);
          check_field("fat_offset", fat_offset_i, want.fat_offset);
          check_field("root_offset", root_offset_i, want.root_offset);
          check_field("data_offset", data_offset_i, want.data_offset);
          check_field("data_bytes", data_bytes_i, want.data_bytes);
        end
        results_seen++;
      end
    end
    pending_o <= expected_layouts.size();
  end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the boot sector checker. The checker module beside
// the block watches both channels, predicts every result and counts mismatches;
// this module only offers items, idles and judges the run.
module tb_top;

  // Roughly 930 random items follow the directed ones.
  localparam int unsigned RandomItems   = 930;
  // The block answers once an item has passed its pipeline; allow a generous margin.
  localparam int unsigned SettleCycles  = 16;
  // Cycles in which neither an item nor a result moves before giving up.
  localparam int unsigned WatchdogLimit = 2000;

  typedef struct packed {
    logic [15:0] sector_bytes;
    logic [7:0]  cluster_sectors;
    logic [15:0] total_short;
    logic [31:0] total_long;
    logic [15:0] reserved;
    logic [15:0] fat_short;
    logic [31:0] fat_long;
    logic [7:0]  fat_copies;
    logic [15:0] root_entries;
    logic [31:0] root_cluster;
  } boot_sector_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [15:0] sector_bytes;
  logic [7:0]  cluster_sectors;
  logic [15:0] total_sectors_short;
  logic [31:0] total_sectors_long;
  logic [15:0] reserved_sectors;
  logic [15:0] fat_sectors_short;
  logic [31:0] fat_sectors_long;
  logic [7:0]  fat_copies;
  logic [15:0] root_entries;
  logic [31:0] root_cluster;
  logic        done;
  logic [5:0]  error_mask;
  logic [1:0]  fat_kind;
  logic [31:0] cluster_total;
  logic [27:0] fat_offset;
  logic [51:0] root_offset;
  logic [52:0] data_offset;
  logic [43:0] data_bytes;
  int unsigned pending;
  int unsigned mismatches;
  int unsigned idle_cycles;

  fat_boot_sector_checker i_dut (
    .clk_i                 (clk),
    .rst_ni                (rst_n),
    .start_i               (start),
    .busy_o                (busy),
    .sector_bytes_i        (sector_bytes),
    .cluster_sectors_i     (cluster_sectors),
    .total_sectors_short_i (total_sectors_short),
    .total_sectors_long_i  (total_sectors_long),
    .reserved_sectors_i    (reserved_sectors),
    .fat_sectors_short_i   (fat_sectors_short),
    .fat_sectors_long_i    (fat_sectors_long),
    .fat_copies_i          (fat_copies),
    .root_entries_i        (root_entries),
    .root_cluster_i        (root_cluster),
    .done_o                (done),
    .error_mask_o          (error_mask),
    .fat_kind_o            (fat_kind),
    .cluster_total_o       (cluster_total),
    .fat_offset_o          (fat_offset),
    .root_offset_o         (root_offset),
    .data_offset_o         (data_offset),
    .data_bytes_o          (data_bytes)
  );

  fbsc_layout_checker i_layout_checker (
    .clk_i                 (clk),
    .rst_ni                (rst_n),
    .start_i               (start),
    .busy_i                (busy),
    .sector_bytes_i        (sector_bytes),
    .cluster_sectors_i     (cluster_sectors),
    .total_sectors_short_i (total_sectors_short),
    .total_sectors_long_i  (total_sectors_long),
    .reserved_sectors_i    (reserved_sectors),
    .fat_sectors_short_i   (fat_sectors_short),
    .fat_sectors_long_i    (fat_sectors_long),
    .fat_copies_i          (fat_copies),
    .root_entries_i        (root_entries),
    .root_cluster_i        (root_cluster),
    .done_i                (done),
    .error_mask_i          (error_mask),
    .fat_kind_i            (fat_kind),
    .cluster_total_i       (cluster_total),
    .fat_offset_i          (fat_offset),
    .root_offset_i         (root_offset),
    .data_offset_i         (data_offset),
    .data_bytes_i          (data_bytes),
    .pending_o             (pending),
    .mismatches_o          (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The watchdog restarts whenever an item is taken or a result appears, so it
  // only fires when the block has stopped answering altogether.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      if (idle_cycles >= WatchdogLimit) begin
        $display("FAIL");
        $finish;
      end
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic boot_sector_t make_sector(
    input logic [15:0] ssz, input logic [7:0] csz,
    input logic [15:0] ts16, input logic [31:0] ts32,
    input logic [15:0] resv, input logic [15:0] fs16, input logic [31:0] fs32,
    input logic [7:0] nfat, input logic [15:0] nroot, input logic [31:0] rclus);
    boot_sector_t s;
    s.sector_bytes    = ssz;
    s.cluster_sectors = csz;
    s.total_short     = ts16;
    s.total_long      = ts32;
    s.reserved        = resv;
    s.fat_short       = fs16;
    s.fat_long        = fs32;
    s.fat_copies      = nfat;
    s.root_entries    = nroot;
    s.root_cluster    = rclus;
    return s;
  endfunction

  // Every field random: mostly errors, and it toggles every input bit.
  function automatic boot_sector_t noise_sector();
    return make_sector(16'($urandom), 8'($urandom), 16'($urandom), $urandom,
                       16'($urandom), 16'($urandom), $urandom, 8'($urandom),
                       16'($urandom), $urandom);
  endfunction

  // A boot sector that passes every check. The total is drawn from several
  // ranges so that all three FAT variants turn up, and the metadata is
  // allowed to overrun the total so that the data count wraps now and then.
  function automatic boot_sector_t sound_sector();
    boot_sector_t s;
    logic [31:0]  total;
    logic [31:0]  fat_limit;
    logic [31:0]  spf;
    bit           long_total;
    s.sector_bytes    = 16'(512 << $urandom_range(0, 3));
    s.cluster_sectors = 8'(1 << $urandom_range(0, 7));
    case ($urandom_range(0, 3))
      0: begin total = $urandom_range(1, 65535);            long_total = 1'b0; end
      1: begin total = $urandom_range(1, 8000);             long_total = 1'b0; end
      2: begin total = $urandom_range(65536, 32'hFF_FFFF);  long_total = 1'b1; end
      default: begin total = $urandom | 32'h1;              long_total = 1'b1; end
    endcase
    if (long_total) begin
      s.total_short = '0;
      s.total_long  = total;
    end else begin
      // The long count is ignored when the short one is set, so fill it anyway.
      s.total_short = total[15:0];
      s.total_long  = $urandom_range(0, 1) ? $urandom : 32'd0;
    end
    if ($urandom_range(0, 3) == 0) begin
      s.reserved = 16'($urandom_range(0, (total > 65535) ? 65535 : total));
    end else begin
      s.reserved = 16'($urandom_range(1, 32));
      if (32'(s.reserved) > total) begin
        s.reserved = total[15:0];
      end
    end
    s.fat_copies = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 255))
                                               : 8'($urandom_range(1, 2));
    if (32'(s.fat_copies) > total) begin
      s.fat_copies = total[7:0];
    end
    fat_limit = total / s.fat_copies;
    case ($urandom_range(0, 2))
      0: spf = $urandom_range(1, (fat_limit > 64) ? 64 : fat_limit);
      1: spf = $urandom_range(1, (fat_limit > 65535) ? 65535 : fat_limit);
      default: spf = $urandom_range(1, fat_limit);
    endcase
    if (spf <= 65535 && $urandom_range(0, 1)) begin
      s.fat_short = spf[15:0];
      s.fat_long  = $urandom_range(0, 1) ? $urandom : 32'd0;
    end else begin
      s.fat_short = '0;
      s.fat_long  = spf;
    end
    case ($urandom_range(0, 2))
      0: s.root_entries = '0;
      1: s.root_entries = 16'd512;
      default: s.root_entries = 16'($urandom);
    endcase
    s.root_cluster = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 3);
    return s;
  endfunction

  // A sound sector with one field spoilt, so that each check fires on its own
  // as well as alongside the others.
  function automatic boot_sector_t spoilt_sector();
    boot_sector_t s;
    s = sound_sector();
    case ($urandom_range(0, 7))
      0: s.sector_bytes = $urandom_range(0, 1) ? (16'($urandom) | 16'h1) : 16'd8192;
      1: s.cluster_sectors = $urandom_range(0, 1) ? 8'd0 : (8'($urandom) | 8'h81);
      2: begin
        s.total_short = '0;
        s.total_long  = '0;
      end
      3: begin
        s.reserved    = 16'hFFFF;
        s.total_short = 16'($urandom_range(1, 65534));
      end
      4: begin
        s.fat_short = '0;
        s.fat_long  = '0;
      end
      5: begin
        s.total_short = 16'($urandom_range(1, 1000));
        s.fat_short   = '0;
        s.fat_long    = $urandom_range(1001, 32'hFFFF_FFFF);
      end
      6: s.fat_copies = '0;
      default: begin
        // FAT area of several copies larger than the whole volume.
        s.total_short = '0;
        s.total_long  = $urandom_range(1, 100000);
        s.fat_short   = '0;
        s.fat_long    = s.total_long;
        s.fat_copies  = 8'($urandom_range(2, 255));
      end
    endcase
    return s;
  endfunction

  // Present one item and hold it until the block takes it.
  task automatic offer(input boot_sector_t s);
    start               <= 1'b1;
    sector_bytes        <= s.sector_bytes;
    cluster_sectors     <= s.cluster_sectors;
    total_sectors_short <= s.total_short;
    total_sectors_long  <= s.total_long;
    reserved_sectors    <= s.reserved;
    fat_sectors_short   <= s.fat_short;
    fat_sectors_long    <= s.fat_long;
    fat_copies          <= s.fat_copies;
    root_entries        <= s.root_entries;
    root_cluster        <= s.root_cluster;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Random gaps between items land on every stage of the pipeline.
  // A gap follows about one item in seven.
  task automatic pause_sender(input bit quiet);
    if (!quiet && $urandom_range(0, 99) < 15) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // Hold off until every outstanding item has produced its result.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    boot_sector_t s;
    int unsigned  roll;
    rst_n               <= 1'b0;
    start               <= 1'b0;
    sector_bytes        <= '0;
    cluster_sectors     <= '0;
    total_sectors_short <= '0;
    total_sectors_long  <= '0;
    reserved_sectors    <= '0;
    fat_sectors_short   <= '0;
    fat_sectors_long    <= '0;
    fat_copies          <= '0;
    root_entries        <= '0;
    root_cluster        <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items. Fields: sector size, cluster size, short and long
    // totals, reserved, short and long FAT size, FAT count, root entries,
    // root cluster.
    // Every field at its lowest, then at its highest.
    offer(make_sector(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    offer(make_sector(16'hFFFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
                      32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF));
    // The smallest sound volume: one sector, no room for data.
    offer(make_sector(512, 1, 1, 0, 0, 1, 0, 1, 0, 0));
    // A classic floppy layout.
    offer(make_sector(512, 1, 2880, 0, 1, 9, 0, 2, 224, 0));
    // Either side of the FAT12/FAT16 threshold: 4084 and 4085 clusters.
    offer(make_sector(512, 1, 4149, 0, 1, 16, 0, 2, 512, 0));
    offer(make_sector(512, 1, 4150, 0, 1, 16, 0, 2, 512, 0));
    // Either side of the FAT16/FAT32 threshold: 65524 and 65525 clusters.
    offer(make_sector(512, 1, 0, 66580, 32, 0, 512, 2, 0, 2));
    offer(make_sector(512, 1, 0, 66581, 32, 0, 512, 2, 0, 2));
    // FAT32 with a root cluster below two, so the cluster index wraps.
    offer(make_sector(4096, 8, 0, 32'h0100_0000, 32, 0, 1000, 2, 0, 0));
    offer(make_sector(2048, 128, 0, 32'h0100_0000, 32, 0, 1000, 2, 0, 1));
    // Largest sound fields; the metadata overruns the total and wraps.
    offer(make_sector(4096, 128, 0, 32'hFFFF_FFFF, 16'hFFFF, 0, 32'd16843009, 255,
                      16'hFFFF, 32'hFFFF_FFFF));
    // A huge root directory pushes the data sector count below zero.
    offer(make_sector(512, 1, 100, 0, 1, 1, 0, 1, 16'hFFFF, 5));
    // With no total at all the checks against the total are skipped.
    offer(make_sector(512, 1, 0, 0, 16'hFFFF, 16'hFFFF, 0, 255, 0, 0));
    // An oversized FAT skips the FAT area check.
    offer(make_sector(512, 1, 10, 0, 0, 20, 0, 255, 0, 0));
    // FAT size zero in both forms, then no FATs, then too many FATs.
    offer(make_sector(512, 1, 1000, 0, 1, 0, 0, 2, 0, 0));
    offer(make_sector(512, 1, 1000, 0, 1, 9, 0, 0, 0, 0));
    offer(make_sector(512, 1, 1000, 0, 1, 400, 0, 3, 0, 0));
    // Reserved area larger than the volume.
    offer(make_sector(512, 1, 1000, 0, 1001, 9, 0, 2, 0, 0));
    // The other legal sector sizes, and some illegal sector and cluster sizes.
    offer(make_sector(1024, 2, 20000, 0, 4, 20, 0, 2, 512, 0));
    offer(make_sector(2048, 64, 0, 500000, 8, 100, 0, 2, 0, 7));
    offer(make_sector(256, 4, 20000, 0, 4, 20, 0, 2, 512, 0));
    offer(make_sector(8192, 3, 20000, 0, 4, 20, 0, 2, 512, 0));
    offer(make_sector(513, 128, 20000, 0, 4, 20, 0, 2, 512, 0));
    // Short forms win over long ones even when the long ones are set.
    offer(make_sector(512, 4, 30000, 32'hDEAD_BEEF, 2, 50, 32'h1234_5678, 2, 128, 9));
    drain_results();

    // Random part: mostly sound sectors with random content, the rest spoilt
    // sectors and pure noise. One stretch runs without any gaps, and halfway
    // through the sender waits for the pipeline to empty.
    for (int unsigned n = 0; n < RandomItems; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        s = sound_sector();
      end else if (roll < 85) begin
        s = spoilt_sector();
      end else begin
        s = noise_sector();
      end
      offer(s);
      if (n == RandomItems / 2) begin
        drain_results();
      end else begin
        pause_sender(n >= 200 && n < 400);
      end
    end

    drain_results();
    // Any stray result after the last expected one would show up here.
    repeat (SettleCycles) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
